// ===== sv/lbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lbc_pkg: block read cache shared definitions
// Field widths, action and status codes, slot entry layout and the
// control structs between the top level and the slot scanner.
// ----------------------------------------------------------------------------
package lbc_pkg;

    localparam int POS_W            = 48;
    localparam int REQ_W            = 32;
    localparam int FILL_W           = 31;
    localparam int GIVE_W           = 31;
    localparam int INB_W            = 16;
    localparam int SLOT_W           = 3;
    localparam int BLOCK_BYTES      = 64 * 1024;
    localparam int BLOCK_BITS       = $clog2(BLOCK_BYTES);
    localparam int LEN_W            = BLOCK_BITS + 1;
    localparam int SMALL_READ_LIMIT = 64 * 1024;
    localparam int DEFAULT_SLOTS    = 8;

    // stream payload layout
    localparam int S_TDATA_W  = 112;
    localparam int M_TDATA_W  = 152;
    localparam int M_SLOT_LSB = 0;
    localparam int M_BLK_LSB  = M_SLOT_LSB + SLOT_W;
    localparam int M_INB_LSB  = M_BLK_LSB + POS_W;
    localparam int M_GIVE_LSB = M_INB_LSB + INB_W;
    localparam int M_POS_LSB  = M_GIVE_LSB + GIVE_W;

    // actions
    localparam logic [1:0] ACT_READ   = 2'd0;
    localparam logic [1:0] ACT_SEEK   = 2'd1;
    localparam logic [1:0] ACT_FILL   = 2'd2;
    localparam logic [1:0] ACT_CANCEL = 2'd3;

    // result status
    localparam logic [2:0] ST_DONE   = 3'd0;
    localparam logic [2:0] ST_EOF    = 3'd1;
    localparam logic [2:0] ST_ERROR  = 3'd2;
    localparam logic [2:0] ST_FETCH  = 3'd3;
    localparam logic [2:0] ST_DIRECT = 3'd4;

    // pending backend operation
    localparam logic [1:0] PEND_NONE   = 2'd0;
    localparam logic [1:0] PEND_BLOCK  = 2'd1;
    localparam logic [1:0] PEND_DIRECT = 2'd2;

    // configuration register indexes
    localparam logic REG_SIZE_KNOWN = 1'b0;
    localparam logic REG_FILE_SIZE  = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0] tag;
        logic [LEN_W-1:0] len;
        logic [POS_W-1:0] stamp;
    } slot_entry_t;

    // an entry never written reads as this
    localparam slot_entry_t SLOT_RESET = '{tag: '1, len: '0, stamp: '0};

    typedef struct packed {
        logic start;
        logic lru;      // 1: find victim, 0: find tag match
    } scan_req_t;

    typedef struct packed {
        logic done;
        logic hit;
    } scan_rsp_t;

endpackage

// ===== sv/lru_block_read_cache_top.sv =====
// ----------------------------------------------------------------------------
// lru_block_read_cache_top: LRU block read cache, tag and policy side
// Keeps the stream position and a fully associative slot store; answers
// reads from cached blocks, requests block fetches and direct reads.
//
//  Channel  Dir  Transfer payload
//  s_axis   in   tuser: action; tdata: target_offset, request_length,
//                fill_bytes, fill_error
//  m_axis   out  tuser: status; tdata: slot, block_offset, in_block,
//                give_length, position
//  cfg      in   cfg_addr 0: size_known, 1: file_size
//
// A small read walks the slot RAM, one entry per cycle; on a hit it then updates
// the entry in the serve state, on a miss it goes straight to advance. A block
// fill walks the RAM and serves as well. Every other item skips scan and serve.
// One item is in work at a time; the next transfer is taken the cycle after a
// result is loaded, while that result may still wait in the output register.
// A stalled output holds the next item at the output stage.
// Reset clears the slot valid bits; no sweep of the slot RAM is needed.
// ----------------------------------------------------------------------------
module lru_block_read_cache_top
    import lbc_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [47:0] target_offset, [79:48] request_length, [110:80] fill_bytes,
    // [111] fill_error
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] action
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [2:0] slot, [50:3] block_offset, [66:51] in_block,
    // [97:67] give_length, [145:98] position, [151:146] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [2:0] status
    output logic [2:0]           m_axis_tuser,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_addr,
    input  logic [POS_W-1:0]     cfg_wdata
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SERVE = 3'd3;
    localparam logic [2:0] S_ADV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam logic [POS_W-1:0] BLK_MASK = ~POS_W'(BLOCK_BYTES - 1);

    // control
    logic [2:0]             state_reg;
    logic [1:0]             pend_kind_reg;
    logic                   cancel_reg;
    logic                   size_known_reg;
    logic [SLOTS-1:0]       valid_reg;
    logic                   m_tvalid_reg;

    // payload
    logic [1:0]             in_act_reg;
    logic [POS_W-1:0]       in_target_reg;
    logic [REQ_W-1:0]       in_req_reg;
    logic [FILL_W-1:0]      in_fill_reg;
    logic                   in_ferr_reg;
    logic [POS_W-1:0]       file_size_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       use_clock_reg;
    logic [FILL_W-1:0]      pend_req_reg;
    logic [POS_W-1:0]       pend_blk_reg;
    logic [POS_W-1:0]       blk_reg;
    logic                   srv_fill_reg;
    logic [LEN_W-1:0]       srv_req_reg;
    logic [LEN_W-1:0]       srv_len_reg;
    logic [IDX_W-1:0]       srv_idx_reg;
    logic [2:0]             res_status_reg;
    logic [SLOT_W-1:0]      res_slot_reg;
    logic [POS_W-1:0]       res_blk_reg;
    logic [INB_W-1:0]       res_inb_reg;
    logic [GIVE_W-1:0]      res_give_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic [2:0]             m_tuser_reg;

    scan_req_t              scan_req;
    scan_rsp_t              scan_rsp;
    logic [IDX_W-1:0]       scan_idx;
    logic [LEN_W-1:0]       scan_len;
    logic                   ram_rd_en;
    logic [IDX_W-1:0]       ram_rd_addr;
    slot_entry_t            ram_rd_data;
    slot_entry_t            ram_wr_data;
    logic                   ram_wr_en;

    logic                   in_xfer;
    logic                   out_load;
    logic [BLOCK_BITS-1:0]  ib;
    logic [LEN_W-1:0]       avail;
    logic [POS_W-1:0]       stamp_next;
    logic [POS_W:0]         pos_sum;
    logic                   req_small;
    logic [FILL_W-1:0]      direct_n;
    logic [LEN_W-1:0]       fill_got;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_load      = (state_reg == S_OUT) && (!m_tvalid_reg || m_axis_tready);

    assign req_small = (in_req_reg <= REQ_W'(SMALL_READ_LIMIT));
    assign direct_n  = ({1'b0, in_fill_reg} < {1'b0, pend_req_reg}) ? in_fill_reg
                                                                    : pend_req_reg;
    assign fill_got  = (in_fill_reg >= FILL_W'(BLOCK_BYTES)) ? LEN_W'(BLOCK_BYTES)
                                                             : in_fill_reg[LEN_W-1:0];

    assign ib         = pos_reg[BLOCK_BITS-1:0];
    assign avail      = srv_len_reg - LEN_W'(ib);
    assign stamp_next = use_clock_reg + (srv_fill_reg ? POS_W'(2) : POS_W'(1));
    assign pos_sum    = {1'b0, pos_reg} + (POS_W + 1)'(res_give_reg);

    assign scan_req.start = (state_reg == S_DEC) &&
                            ((in_act_reg == ACT_READ && !cancel_reg &&
                              pend_kind_reg == PEND_NONE && !in_req_reg[REQ_W-1] &&
                              in_req_reg != '0 &&
                              !(size_known_reg && pos_reg >= file_size_reg) &&
                              req_small) ||
                             (in_act_reg == ACT_FILL && !cancel_reg && !in_ferr_reg &&
                              pend_kind_reg == PEND_BLOCK && in_fill_reg != '0));
    assign scan_req.lru   = (in_act_reg == ACT_FILL);

    assign ram_wr_en        = (state_reg == S_SERVE);
    assign ram_wr_data.tag   = blk_reg;
    assign ram_wr_data.len   = srv_len_reg;
    assign ram_wr_data.stamp = stamp_next;

    lbc_ram #(
        .WIDTH ($bits(slot_entry_t)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (srv_idx_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lbc_slot_scan #(
        .SLOTS (SLOTS)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (scan_req),
        .blk        (blk_reg),
        .valid_bits (valid_reg),
        .rd_data    (ram_rd_data),
        .rd_en      (ram_rd_en),
        .rd_addr    (ram_rd_addr),
        .rsp        (scan_rsp),
        .res_idx    (scan_idx),
        .res_len    (scan_len)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pend_kind_reg  <= PEND_NONE;
            cancel_reg     <= 1'b0;
            size_known_reg <= 1'b0;
            valid_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en && cfg_addr == REG_SIZE_KNOWN) begin
                size_known_reg <= cfg_wdata[0];
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_xfer) begin
                        state_reg <= S_DEC;
                    end
                end
                S_DEC: begin
                    state_reg <= scan_req.start ? S_SCAN : S_ADV;
                    case (in_act_reg)
                        ACT_READ: begin
                            if (!cancel_reg && pend_kind_reg == PEND_NONE &&
                                !in_req_reg[REQ_W-1] && in_req_reg != '0 &&
                                !(size_known_reg && pos_reg >= file_size_reg) &&
                                !req_small) begin
                                pend_kind_reg <= PEND_DIRECT;
                            end
                        end
                        ACT_SEEK: begin
                            if (!in_target_reg[POS_W-1]) begin
                                pend_kind_reg <= PEND_NONE;
                            end
                        end
                        ACT_CANCEL: begin
                            cancel_reg <= 1'b1;
                        end
                        default: begin
                            pend_kind_reg <= PEND_NONE;
                        end
                    endcase
                end
                S_SCAN: begin
                    if (scan_rsp.done) begin
                        if (srv_fill_reg || scan_rsp.hit) begin
                            state_reg <= S_SERVE;
                        end else begin
                            pend_kind_reg <= PEND_BLOCK;
                            state_reg     <= S_ADV;
                        end
                    end
                end
                S_SERVE: begin
                    valid_reg[srv_idx_reg] <= 1'b1;
                    state_reg              <= S_ADV;
                end
                S_ADV: begin
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_size_reg <= '0;
            pos_reg       <= '0;
            use_clock_reg <= '0;
            pend_req_reg  <= '0;
            pend_blk_reg  <= '0;
        end else begin
            if (cfg_wr_en && cfg_addr == REG_FILE_SIZE) begin
                file_size_reg <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_xfer) begin
                        in_act_reg    <= s_axis_tuser;
                        in_target_reg <= s_axis_tdata[47:0];
                        in_req_reg    <= s_axis_tdata[79:48];
                        in_fill_reg   <= s_axis_tdata[110:80];
                        in_ferr_reg   <= s_axis_tdata[111];
                    end
                end
                S_DEC: begin
                    res_slot_reg   <= '0;
                    res_blk_reg    <= '0;
                    res_inb_reg    <= '0;
                    srv_fill_reg   <= (in_act_reg == ACT_FILL);
                    case (in_act_reg)
                        ACT_READ: begin
                            blk_reg     <= pos_reg & BLK_MASK;
                            srv_req_reg <= in_req_reg[LEN_W-1:0];
                            if (cancel_reg || pend_kind_reg != PEND_NONE) begin
                                res_status_reg <= ST_ERROR;
                                res_give_reg   <= '0;
                            end else if (in_req_reg[REQ_W-1] || in_req_reg == '0) begin
                                res_status_reg <= ST_DONE;
                                res_give_reg   <= '0;
                            end else if (size_known_reg && pos_reg >= file_size_reg) begin
                                res_status_reg <= ST_EOF;
                                res_give_reg   <= '0;
                            end else if (!req_small) begin
                                pend_req_reg   <= in_req_reg[FILL_W-1:0];
                                res_status_reg <= ST_DIRECT;
                                res_give_reg   <= in_req_reg[GIVE_W-1:0];
                            end else begin
                                res_status_reg <= ST_DONE;
                                res_give_reg   <= '0;
                            end
                        end
                        ACT_SEEK: begin
                            res_give_reg <= '0;
                            if (in_target_reg[POS_W-1]) begin
                                res_status_reg <= ST_ERROR;
                            end else begin
                                res_status_reg <= ST_DONE;
                                pos_reg        <= in_target_reg;
                            end
                        end
                        ACT_CANCEL: begin
                            res_status_reg <= ST_DONE;
                            res_give_reg   <= '0;
                        end
                        default: begin
                            // fill complete
                            blk_reg     <= pend_blk_reg;
                            srv_req_reg <= pend_req_reg[LEN_W-1:0];
                            srv_len_reg <= fill_got;
                            if (pend_kind_reg == PEND_NONE || cancel_reg || in_ferr_reg) begin
                                res_status_reg <= ST_ERROR;
                                res_give_reg   <= '0;
                            end else if (pend_kind_reg == PEND_BLOCK) begin
                                res_status_reg <= (in_fill_reg == '0) ? ST_ERROR : ST_DONE;
                                res_give_reg   <= '0;
                            end else begin
                                res_status_reg <= ST_DONE;
                                res_give_reg   <= direct_n;
                            end
                        end
                    endcase
                end
                S_SCAN: begin
                    if (scan_rsp.done) begin
                        srv_idx_reg <= scan_idx;
                        if (!srv_fill_reg) begin
                            if (scan_rsp.hit) begin
                                srv_len_reg <= scan_len;
                            end else begin
                                pend_req_reg   <= FILL_W'(srv_req_reg);
                                pend_blk_reg   <= blk_reg;
                                res_status_reg <= ST_FETCH;
                                res_blk_reg    <= blk_reg;
                            end
                        end
                    end
                end
                S_SERVE: begin
                    use_clock_reg <= stamp_next;
                    res_slot_reg  <= SLOT_W'(srv_idx_reg);
                    res_blk_reg   <= blk_reg;
                    res_inb_reg   <= INB_W'(ib);
                    if (LEN_W'(ib) >= srv_len_reg) begin
                        res_status_reg <= ST_EOF;
                        res_give_reg   <= '0;
                    end else begin
                        res_status_reg <= ST_DONE;
                        res_give_reg   <= GIVE_W'((srv_req_reg < avail) ? srv_req_reg : avail);
                    end
                end
                S_ADV: begin
                    // a direct read request moves the position only on its fill;
                    // saturate at the top of the 48-bit range
                    if (res_status_reg != ST_DIRECT) begin
                        pos_reg <= pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tuser_reg <= res_status_reg;
            m_tdata_reg <= {(M_TDATA_W - M_POS_LSB - POS_W)'(0), pos_reg, res_give_reg,
                            res_inb_reg, res_blk_reg, res_slot_reg};
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

endmodule

// ===== sv/lbc_ram.sv =====
// ----------------------------------------------------------------------------
// lbc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/lbc_slot_scan.sv =====
// ----------------------------------------------------------------------------
// lbc_slot_scan: slot walker
// Reads every slot entry once, one per cycle, and finds either the first
// slot whose tag matches a block or the least-recently-used slot.
// ----------------------------------------------------------------------------
module lbc_slot_scan
    import lbc_pkg::*;
#(
    parameter int SLOTS = DEFAULT_SLOTS,
    parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  scan_req_t         req,
    input  logic [POS_W-1:0]  blk,
    input  logic [SLOTS-1:0]  valid_bits,
    input  slot_entry_t       rd_data,
    output logic              rd_en,
    output logic [IDX_W-1:0]  rd_addr,
    output scan_rsp_t         rsp,
    output logic [IDX_W-1:0]  res_idx,
    output logic [LEN_W-1:0]  res_len
);

    localparam int CNT_W = $clog2(SLOTS + 1);

    logic             busy_reg;
    logic             lru_reg;
    logic [CNT_W-1:0] issue_cnt_reg;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             found_reg;
    logic             done_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [LEN_W-1:0] best_len_reg;
    logic [POS_W-1:0] best_stamp_reg;
    slot_entry_t      ent;
    logic             last_cmp;

    assign rd_en   = busy_reg && (issue_cnt_reg != CNT_W'(SLOTS));
    assign rd_addr = issue_cnt_reg[IDX_W-1:0];

    // slots never filled read as the reset entry
    assign ent      = valid_bits[cmp_idx_reg] ? rd_data : SLOT_RESET;
    assign last_cmp = cmp_vld_reg && (cmp_idx_reg == IDX_W'(SLOTS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            done_reg      <= 1'b0;
            issue_cnt_reg <= '0;
        end else begin
            done_reg    <= last_cmp;
            cmp_vld_reg <= rd_en;
            if (req.start) begin
                busy_reg      <= 1'b1;
                issue_cnt_reg <= '0;
            end else begin
                if (rd_en) begin
                    issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
                end
                if (last_cmp) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= rd_addr;
        if (req.start) begin
            lru_reg   <= req.lru;
            found_reg <= 1'b0;
        end else if (cmp_vld_reg) begin
            if (lru_reg) begin
                // strict compare keeps the lowest slot on a tie
                if (cmp_idx_reg == '0 || ent.stamp < best_stamp_reg) begin
                    best_idx_reg   <= cmp_idx_reg;
                    best_stamp_reg <= ent.stamp;
                end
            end else if (!found_reg && ent.tag == blk) begin
                found_reg    <= 1'b1;
                best_idx_reg <= cmp_idx_reg;
                best_len_reg <= ent.len;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.hit  = found_reg;
    assign res_idx  = best_idx_reg;
    assign res_len  = best_len_reg;

endmodule

// ===== sv/lbc_checker.sv =====
// ----------------------------------------------------------------------------
// lbc_checker: port-level checks for the block read cache
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module lbc_checker
    import lbc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [2:0]           m_axis_tuser
);

    // one item in work at a time
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item is still in work");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    a_fetch_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == ST_FETCH) |->
        (m_axis_tdata[M_BLK_LSB +: BLOCK_BITS] == '0 &&
         m_axis_tdata[M_GIVE_LSB +: GIVE_W] == '0))
        else $error("fetch request not block aligned or carries a length");

    a_no_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser == ST_EOF || m_axis_tuser == ST_ERROR)) |->
        (m_axis_tdata[M_GIVE_LSB +: GIVE_W] == '0))
        else $error("end of file or error result with nonzero length");

endmodule

bind lru_block_read_cache_top lbc_checker u_lbc_checker (.*);
